@@ rtl/core/set_assoc_lru_writeback_cache_unit_macros.svh @@
// Assertion macros shared by the cache tag store RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define SLC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/slc_pkg.sv @@
// Package of the cache tag store: field widths, register indexes and config type.
// Used by the interfaces, front end, back end and top of the block; depends on nothing.
`default_nettype none
package slc_pkg;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned IN_ADDR_W   = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned DIRTY_W     = 28;
  localparam int unsigned EVICT_W     = 48;
  localparam int unsigned BB_W        = 17;
  localparam logic [4:0]  MAX_BLOCK_BITS = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;
endpackage
`default_nettype wire

@@ rtl/core/slc_if.sv @@
// Handshake interfaces for the access channel and the result channel.
// Depends on slc_pkg for field widths.
`default_nettype none
interface slc_req_if import slc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [IN_ADDR_W-1:0] address;
  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

interface slc_rsp_if import slc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               miss;
  logic               eviction;
  logic               made_dirty;
  logic               dirty_eviction;
  logic [CNT_W-1:0]   hit_total;
  logic [CNT_W-1:0]   miss_total;
  logic [CNT_W-1:0]   eviction_total;
  logic [DIRTY_W-1:0] dirty_bytes_now;
  logic [EVICT_W-1:0] dirty_evicted_bytes;
  modport source (output valid, hit, miss, eviction, made_dirty, dirty_eviction, hit_total,
                  miss_total, eviction_total, dirty_bytes_now, dirty_evicted_bytes,
                  input ready);
  modport sink (input valid, hit, miss, eviction, made_dirty, dirty_eviction, hit_total,
                miss_total, eviction_total, dirty_bytes_now, dirty_evicted_bytes,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/slc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/slc_front.sv @@
// Front end: accepts accesses, splits the address into set and tag, queues them.
// Depends on slc_pkg and slc_req_if.
`default_nettype none
module slc_front import slc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS  = 8,
  parameter int unsigned ADDRESS_WIDTH = 64,
  localparam int unsigned SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  slc_req_if.sink                       req_i,
  output      logic                     q_valid_o,
  input  wire logic                     q_pop_i,
  output      logic                     q_store_o,
  output      logic [SW-1:0]            q_set_o,
  output      logic [ADDRESS_WIDTH-1:0] q_tag_o
);
  localparam int unsigned QD = 2;

  logic [4:0]               s_eff, b_eff;
  logic [5:0]               shamt;
  logic [ADDRESS_WIDTH-1:0] addr, set_mask, tag, set_wide;
  logic                     push;

  logic                     st_q   [QD];
  logic [SW-1:0]            set_q  [QD];
  logic [ADDRESS_WIDTH-1:0] tag_q  [QD];
  logic                     wp_q, rp_q;
  logic [1:0]               cnt_q;

  always_comb begin
    s_eff = ({1'b0, cfg_i.set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                        : {1'b0, cfg_i.set_bits};
    b_eff = (cfg_i.block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : cfg_i.block_bits;
    shamt = 6'(s_eff) + 6'(b_eff);
    addr = req_i.address[ADDRESS_WIDTH-1:0];
    set_mask = (ADDRESS_WIDTH'(1) << s_eff) - ADDRESS_WIDTH'(1);
    tag = addr >> shamt;
    set_wide = (addr >> b_eff) & set_mask;
  end

  assign req_i.ready = (cnt_q != 2'(QD));
  assign push = req_i.valid && req_i.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_store_o = st_q[rp_q];
  assign q_set_o = set_q[rp_q];
  assign q_tag_o = tag_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      st_q[wp_q] <= req_i.command;
      set_q[wp_q] <= set_wide[SW-1:0];
      tag_q[wp_q] <= tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/slc_back.sv @@
// Back end: reads a set row, resolves hit, fill or eviction, updates LRU ranks and totals.
// Depends on slc_pkg, slc_rsp_if, slc_ram and the assertion macro header.
`default_nettype none
`include "set_assoc_lru_writeback_cache_unit_macros.svh"
module slc_back import slc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS  = 8,
  parameter int unsigned MAX_WAYS      = 8,
  parameter int unsigned ADDRESS_WIDTH = 64,
  localparam int unsigned SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     q_valid_i,
  output      logic                     q_pop_o,
  input  wire logic                     q_store_i,
  input  wire logic [SW-1:0]            q_set_i,
  input  wire logic [ADDRESS_WIDTH-1:0] q_tag_i,
  slc_rsp_if.source                     rsp_o
);
  localparam int unsigned SETS = 1 << MAX_SET_BITS;
  localparam int unsigned RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCW  = $clog2(MAX_WAYS + 1);
  localparam int unsigned LW   = 2 + RW + ADDRESS_WIDTH;
  localparam int unsigned ROWW = MAX_WAYS * LW;
  localparam logic [RW:0]      RANK_TOP = (RW + 1)'(MAX_WAYS - 1);
  localparam logic [DIRTY_W:0] DMAX = {1'b0, {DIRTY_W{1'b1}}};
  localparam logic [EVICT_W:0] EMAX = {1'b0, {EVICT_W{1'b1}}};

  typedef enum logic {ST_IDLE, ST_UPDATE} state_e;
  state_e state_q;

  logic [SETS-1:0]          row_ok_q;
  logic                     row_ok_rd_q;
  logic                     store_q;
  logic [SW-1:0]            set_q;
  logic [ADDRESS_WIDTH-1:0] tag_q;
  logic [ROWW-1:0]          rd_row, wr_row;
  logic                     commit, out_free;

  logic                     lv [MAX_WAYS];
  logic                     ld [MAX_WAYS];
  logic [RW-1:0]            lr [MAX_WAYS];
  logic [ADDRESS_WIDTH-1:0] lt [MAX_WAYS];
  logic                     inuse [MAX_WAYS];

  logic [WCW-1:0]  ways_eff;
  logic            hit, free, evict, md, de;
  logic [RW-1:0]   target, best;
  logic [RW:0]     limit;
  logic [BB_W-1:0] bb;
  logic [DIRTY_W:0] dsum, dnew;
  logic [EVICT_W:0] enew;

  logic             hit_d, miss_d, ev_d, md_d, de_d;
  logic [CNT_W-1:0] hc_q, mc_q, ec_q;
  logic [DIRTY_W-1:0] dc_q;
  logic [EVICT_W-1:0] xc_q;
  logic             out_v_q;

  slc_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(set_q),
    .wdata_i(wr_row),
    .re_i   (q_pop_o),
    .raddr_i(q_set_i),
    .rdata_o(rd_row)
  );

  assign out_free = !out_v_q || rsp_o.ready;
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign commit = (state_q == ST_UPDATE) && out_free;

  always_comb begin
    if (cfg_i.ways_in_use == 4'd0) ways_eff = WCW'(1);
    else if (32'(cfg_i.ways_in_use) > MAX_WAYS) ways_eff = WCW'(MAX_WAYS);
    else ways_eff = WCW'(cfg_i.ways_in_use);

    for (int w = 0; w < MAX_WAYS; w++) begin
      {lv[w], ld[w], lr[w], lt[w]} = row_ok_rd_q ? rd_row[w*LW +: LW] : '0;
      inuse[w] = (WCW'(w) < ways_eff);
    end

    hit = 1'b0;
    free = 1'b0;
    target = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (inuse[w] && lv[w] && lt[w] == tag_q) begin
        hit = 1'b1;
        target = RW'(w);
      end
    end
    if (!hit) begin
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
        if (inuse[w] && !lv[w]) begin
          free = 1'b1;
          target = RW'(w);
        end
      end
    end
    // Oldest line: first way holding the largest rank.
    best = '0;
    if (!hit && !free) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (inuse[w] && lr[w] > best) begin
          best = lr[w];
          target = RW'(w);
        end
      end
    end
    evict = !hit && !free;
    limit = free ? (RW + 1)'(MAX_WAYS) : {1'b0, lr[target]};
    // A hit store sets made_dirty only on a clean line; a miss store always does.
    md = store_q && (!hit || !ld[target]);
    de = evict && ld[target];

    for (int w = 0; w < MAX_WAYS; w++) begin
      wr_row[w*LW +: LW] = {lv[w], ld[w], lr[w], lt[w]};
      if (RW'(w) == target) begin
        wr_row[w*LW +: LW] = {1'b1, (store_q || (ld[w] && !evict)), RW'(0), tag_q};
      end else if (inuse[w] && lv[w] && {1'b0, lr[w]} < limit && {1'b0, lr[w]} < RANK_TOP) begin
        wr_row[w*LW +: LW] = {lv[w], ld[w], RW'(lr[w] + RW'(1)), lt[w]};
      end
    end

    bb = BB_W'(1) << ((cfg_i.block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : cfg_i.block_bits);
    dsum = {1'b0, dc_q};
    if (md) dsum = (DMAX - {1'b0, dc_q} < (DIRTY_W + 1)'(bb)) ? DMAX
                                                              : {1'b0, dc_q} + (DIRTY_W + 1)'(bb);
    dnew = dsum;
    enew = {1'b0, xc_q};
    if (de) begin
      dnew = (dsum < (DIRTY_W + 1)'(bb)) ? '0 : dsum - (DIRTY_W + 1)'(bb);
      enew = (EMAX - {1'b0, xc_q} < (EVICT_W + 1)'(bb)) ? EMAX
                                                        : {1'b0, xc_q} + (EVICT_W + 1)'(bb);
    end

    hit_d = hit;
    miss_d = !hit;
    ev_d = evict;
    md_d = md;
    de_d = de;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      store_q <= q_store_i;
      set_q <= q_set_i;
      tag_q <= q_tag_i;
    end
    if (commit) begin
      rsp_o.hit <= hit_d;
      rsp_o.miss <= miss_d;
      rsp_o.eviction <= ev_d;
      rsp_o.made_dirty <= md_d;
      rsp_o.dirty_eviction <= de_d;
      rsp_o.hit_total <= (hit_d && hc_q != '1) ? hc_q + CNT_W'(1) : hc_q;
      rsp_o.miss_total <= (miss_d && mc_q != '1) ? mc_q + CNT_W'(1) : mc_q;
      rsp_o.eviction_total <= (ev_d && ec_q != '1) ? ec_q + CNT_W'(1) : ec_q;
      rsp_o.dirty_bytes_now <= dnew[DIRTY_W-1:0];
      rsp_o.dirty_evicted_bytes <= enew[EVICT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_ok_q <= '0;
      row_ok_rd_q <= 1'b0;
      out_v_q <= 1'b0;
      hc_q <= '0;
      mc_q <= '0;
      ec_q <= '0;
      dc_q <= '0;
      xc_q <= '0;
    end else begin
      if (rsp_o.ready && !commit) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            row_ok_rd_q <= row_ok_q[q_set_i];
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (commit) begin
            row_ok_q[set_q] <= 1'b1;
            out_v_q <= 1'b1;
            if (hit_d && hc_q != '1) hc_q <= hc_q + CNT_W'(1);
            if (miss_d && mc_q != '1) mc_q <= mc_q + CNT_W'(1);
            if (ev_d && ec_q != '1) ec_q <= ec_q + CNT_W'(1);
            dc_q <= dnew[DIRTY_W-1:0];
            xc_q <= enew[EVICT_W-1:0];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid = out_v_q;

  `SLC_ASSERT(a_hit_xor_miss, rsp_o.valid |-> (rsp_o.hit ^ rsp_o.miss), "hit and miss clash")
  `SLC_ASSERT(a_evict_on_miss, (rsp_o.valid && rsp_o.eviction) |-> rsp_o.miss, "eviction on hit")
  `SLC_ASSERT(a_dirty_evict, (rsp_o.valid && rsp_o.dirty_eviction) |-> rsp_o.eviction, "bad dirty")
  `SLC_NEVER(a_pop_busy, q_pop_o && state_q == ST_UPDATE, "queue popped while set update pending")
endmodule
`default_nettype wire

@@ rtl/core/set_assoc_lru_writeback_cache_unit.sv @@
// Cache tag store: one access in, one result out. Each access passes the front queue, then
// the queue pop with set row read, then the update, whose result is registered. The back end
// handles one access at a time, as it reads and then writes one set row in the tag RAM.
// A stalled result holds the back end only; the front queue still takes up to two accesses.
// Reset clears the totals and marks every set row empty through one valid flag per row,
// so no clearing pass is needed and the block takes accesses right after reset.
`default_nettype none
module set_assoc_lru_writeback_cache_unit import slc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS  = 8,
  parameter int unsigned MAX_WAYS      = 8,
  parameter int unsigned ADDRESS_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  slc_req_if.sink                    req_i,
  slc_rsp_if.source                  rsp_o
);
  localparam int unsigned SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  cfg_t                     cfg_q;
  logic                     q_valid, q_pop, q_store;
  logic [SW-1:0]            q_set;
  logic [ADDRESS_WIDTH-1:0] q_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{set_bits: 4'd0, block_bits: 5'd0, ways_in_use: 4'd1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   cfg_q.set_bits <= cfg_data_i[3:0];
        CFG_BLOCK_BITS: cfg_q.block_bits <= cfg_data_i;
        CFG_WAYS:       cfg_q.ways_in_use <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  slc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDRESS_WIDTH(ADDRESS_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .req_i    (req_i),
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_store_o(q_store),
    .q_set_o  (q_set),
    .q_tag_o  (q_tag)
  );

  slc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
             .ADDRESS_WIDTH(ADDRESS_WIDTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .q_store_i(q_store),
    .q_set_i  (q_set),
    .q_tag_i  (q_tag),
    .rsp_o    (rsp_o)
  );
endmodule
`default_nettype wire
